>>> hdl/sida_pkg.sv
`timescale 1ns / 1ps

package sida_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned NUM_DIG = 10;                 // max decimal digits of 2^31
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned BCD_W   = NUM_DIG * DIG_W;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned CNT_W   = $clog2(VALUE_W + 1);
  localparam int unsigned REM_W   = $clog2(NUM_DIG + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // control from the sequencer to the BCD shifter
  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctrl_t;

endpackage

>>> hdl/sida_bcd.sv
`timescale 1ns / 1ps

// Bit-serial double dabble: one binary bit enters per cycle.
// After conversion, shift moves the digit string up by one digit.
module sida_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sida_pkg::bcd_ctrl_t           ctrl_i,
  input  logic [sida_pkg::VALUE_W-1:0]  mag_i,
  output logic                          done_o,
  output logic [sida_pkg::DIG_W-1:0]    top_digit_o
);
  import sida_pkg::*;

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   adj;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd_q[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (ctrl_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = CNT_W'(VALUE_W);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      run_d = (cnt_q != CNT_W'(1));
    end else if (ctrl_i.shift) begin
      bcd_d = {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o      = run_q && (cnt_q == CNT_W'(1));
  assign top_digit_o = bcd_q[BCD_W-1 -: DIG_W];

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII. A transaction is taken when start_i
// is high and busy_o is low; the block then stays busy until its last
// character has been issued. Characters leave most significant first, one per
// cycle, each marked by strobe_o for exactly one cycle, with last_o set on the
// final one; the receiver cannot stall them. A negative value gets a leading
// '-' (the most negative value included); zero gives "0"; no leading zeros.
// Steps per transaction: accept, bit-serial binary to BCD conversion (one
// input bit per cycle through the double-dabble shifter), dropping up to nine
// leading zero digits, then the characters (1 to 11). A new start can be
// taken the cycle after the final character is chosen. Skipped and emitted
// digits always total ten.
module signed_int_to_decimal_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [31:0]            value_i,
  output logic                          strobe_o,
  output logic [sida_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_o
);
  import sida_pkg::*;

  state_e             state_q, state_d;
  logic               neg_q, neg_d;
  logic [REM_W-1:0]   rem_q, rem_d;        // digits still in the BCD string
  logic               strobe_q, strobe_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  bcd_ctrl_t          bcd_ctrl;
  logic [VALUE_W-1:0] mag;
  logic               bcd_done;
  logic [DIG_W-1:0]   top_digit;
  logic               accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // two's complement magnitude; the most negative value maps to 2^31 unsigned
  assign mag = value_i[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value_i)) : VALUE_W'(value_i);

  sida_bcd u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (bcd_ctrl),
    .mag_i       (mag),
    .done_o      (bcd_done),
    .top_digit_o (top_digit)
  );

  always_comb begin
    state_d        = state_q;
    neg_d          = neg_q;
    rem_d          = rem_q;
    strobe_d       = 1'b0;
    char_d         = char_q;
    last_d         = last_q;
    bcd_ctrl.load  = 1'b0;
    bcd_ctrl.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          bcd_ctrl.load = 1'b1;
          neg_d         = value_i[VALUE_W-1];
          rem_d         = REM_W'(NUM_DIG);
          state_d       = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if ((top_digit == '0) && (rem_q != REM_W'(1))) begin
          bcd_ctrl.shift = 1'b1;
          rem_d          = rem_q - 1'b1;
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        strobe_d = 1'b1;
        char_d   = CHAR_MINUS;
        last_d   = 1'b0;
        state_d  = ST_DIGIT;
      end
      ST_DIGIT: begin
        strobe_d       = 1'b1;
        char_d         = CHAR_ZERO + CHAR_W'(top_digit);
        last_d         = (rem_q == REM_W'(1));
        bcd_ctrl.shift = 1'b1;
        rem_d          = rem_q - 1'b1;
        if (rem_q == REM_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // characters are only a minus or a digit
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (char_code_o == CHAR_MINUS) ||
                 ((char_code_o >= CHAR_ZERO) && (char_code_o <= CHAR_ZERO + CHAR_W'(9))))
    else $error("illegal character code");

  // a minus sign is never the final character and is followed by a digit
  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (char_code_o == CHAR_MINUS)) |-> !last_o ##1
      (strobe_o && (char_code_o != CHAR_MINUS)))
    else $error("minus sign not followed by a digit");

  // conversion leaves a gap: nothing right after the last character
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("character issued right after last");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !strobe_o))
    else $error("accept did not start a conversion");

endmodule

>>> test/text_sb_pkg.sv
`timescale 1ns / 1ps

package text_sb_pkg;

  import sida_pkg::*;

  localparam logic [31:0] RADIX = 32'd10;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } char_item_t;

  class char_scoreboard;
    char_item_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Queue the characters that an accepted value must produce.
    function void note_value(logic [31:0] value);
      logic [31:0] mag;
      logic [3:0]  digs[NUM_DIG];
      int          n;
      char_item_t  item;
      mag = value[31] ? (32'd0 - value) : value;
      n = 0;
      do begin
        digs[n] = 4'(mag % RADIX);
        mag = mag / RADIX;
        n++;
      end while (mag != 0 && n < NUM_DIG);
      if (value[31]) begin
        item.code = CHAR_MINUS;
        item.is_last = 1'b0;
        expected_chars.push_back(item);
      end
      for (int k = n - 1; k >= 0; k--) begin
        item.code = CHAR_ZERO + CHAR_W'(digs[k]);
        item.is_last = (k == 0);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic is_last);
      char_item_t item;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, code, is_last);
        errors++;
        return;
      end
      item = expected_chars.pop_front();
      if (code !== item.code) begin
        $display("%0t: char_code mismatch: expected %0d, actual %0d",
                 $time, item.code, code);
        errors++;
      end
      if (is_last !== item.is_last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b",
                 $time, item.is_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

endpackage

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import text_sb_pkg::*;

  // Longest quiet stretch is a full conversion plus the longest sender gap;
  // this is many times that.
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_GAP        = 20;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ITEMS_PER_PHASE = 35;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic signed [31:0]          value_i;
  logic                        strobe_o;
  logic [sida_pkg::CHAR_W-1:0] char_code_o;
  logic                        last_o;

  char_scoreboard sb;
  int             idle_pct;

  signed_int_to_decimal_ascii u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Characters cannot be held off, so every strobe is checked at the edge
  // that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_char(char_code_o, last_o);
    end
  end

  // Watchdog: give up after too many cycles with no transaction and no
  // character.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || strobe_o) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

  // Number of idle cycles before the next transaction, drawn per cycle.
  function automatic int idle_gap();
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP) begin
      gap++;
    end
    return gap;
  endfunction

  // Half fully random words (mostly ten digits), half with a random digit
  // count so that every text length shows up often.
  function automatic logic [31:0] random_value();
    int unsigned     digits;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    logic [31:0]     v;
    if ($urandom_range(1) == 0) begin
      return $urandom();
    end
    digits = $urandom_range(10, 1);
    lo = 1;
    repeat (digits - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    if (digits == 1) lo = 0;
    mag = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
    v = mag[31:0];
    if ($urandom_range(1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  // Entered and left at a falling edge. start_i stays high straight into the
  // next transaction when there is no gap, so it is never dropped and raised
  // in the same step.
  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      value_i = $urandom();
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    value_i = v;
    do @(posedge clk_i); while (busy_o);
    sb.note_value(v);
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    logic [31:0] corner[$];
    corner = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
               32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
               32'd1000000000, 32'd999999999, -32'sd999999999,
               32'd1234567890, -32'sd1234567890, 32'h5555_5555,
               32'hAAAA_AAAA, -32'sd1, 32'd5};
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_value(random_value());
  endtask

  initial begin
    sb       = new();
    idle_pct = 0;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    value_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corners back to back
    run_directed();

    // Idle phases: none, sender 45%, sender 32% (the receiver side has no
    // stall to apply), then none again.
    idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    idle_pct = 45;
    run_random(ITEMS_PER_PHASE);
    idle_pct = 32;
    run_random(ITEMS_PER_PHASE);
    idle_pct = 0;
    run_random(ITEMS_PER_PHASE);

    start_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray characters after the expected ones
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sida_pkg.sv
hdl/sida_bcd.sv
hdl/signed_int_to_decimal_ascii.sv
test/text_sb_pkg.sv
test/testbench.sv
